// ===== src/mstk_pkg.sv =====
// Shared types and constants for the Kruskal spanning tree block.
package mstk_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;
    localparam int VID_BITS     = $clog2(MAX_VERTICES);
    localparam int VC_BITS      = 7;
    localparam int CNT_BITS     = $clog2(MAX_EDGES + 1);

    typedef struct packed {
        logic [VID_BITS-1:0]           src;
        logic [VID_BITS-1:0]           dst;
        logic signed [WEIGHT_BITS-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic init;
        logic relabel;
        logic [VID_BITS-1:0] keep_label;
        logic [VID_BITS-1:0] old_label;
    } vtx_ctl_t;

endpackage

// ===== src/mstk_if.sv =====
// Valid/ready channel interfaces for edges in and tree edges out.
interface mstk_edge_if;
    logic                                   valid;
    logic                                   ready;
    logic [mstk_pkg::VID_BITS-1:0]          edge_src;
    logic [mstk_pkg::VID_BITS-1:0]          edge_dest;
    logic signed [mstk_pkg::WEIGHT_BITS-1:0] edge_weight;
    logic                                   last_edge;

    modport source (output valid, edge_src, edge_dest, edge_weight, last_edge, input ready);
    modport sink   (input valid, edge_src, edge_dest, edge_weight, last_edge, output ready);
endinterface

interface mstk_tree_if;
    logic                                   valid;
    logic                                   ready;
    logic [mstk_pkg::VID_BITS-1:0]          tree_src;
    logic [mstk_pkg::VID_BITS-1:0]          tree_dest;
    logic signed [mstk_pkg::WEIGHT_BITS-1:0] tree_weight;
    logic                                   last_of_tree;
    logic                                   empty_tree;
    logic                                   edges_dropped;

    modport source (output valid, tree_src, tree_dest, tree_weight, last_of_tree,
                    empty_tree, edges_dropped, input ready);
    modport sink   (input valid, tree_src, tree_dest, tree_weight, last_of_tree,
                    empty_tree, edges_dropped, output ready);
endinterface

// ===== src/mstk_sort_cell.sv =====
// One cell of the sorted edge chain: insertion on arrival, left shift on scan.
module mstk_sort_cell
(
    input  logic                clk,
    input  mstk_pkg::cell_ctl_t ctl,
    input  logic                occ,
    input  mstk_pkg::edge_t     new_edge,
    input  mstk_pkg::edge_t     prev_edge,
    input  logic                prev_gt,
    input  mstk_pkg::edge_t     succ_edge,
    output mstk_pkg::edge_t     edge_q,
    output logic                gt
);

    mstk_pkg::edge_t edge_reg;

    // Empty cells count as heavier than anything; ties stay ahead of the new edge.
    assign gt     = !occ || (edge_reg.weight > new_edge.weight);
    assign edge_q = edge_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.insert && gt)
        begin
            edge_reg <= prev_gt ? prev_edge : new_edge;
        end
        else if (ctl.shift)
        begin
            edge_reg <= succ_edge;
        end
    end

endmodule

// ===== src/mstk_vertex_cell.sv =====
// One vertex cell: holds the component label of its vertex.
module mstk_vertex_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [mstk_pkg::VID_BITS-1:0]      own_id,
    input  mstk_pkg::vtx_ctl_t                 ctl,
    output logic [mstk_pkg::VID_BITS-1:0]      label
);

    logic [mstk_pkg::VID_BITS-1:0] label_reg;

    assign label = label_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= own_id;
        end
        else if (ctl.init)
        begin
            label_reg <= own_id;
        end
        else if (ctl.relabel && label_reg == ctl.old_label)
        begin
            // merge: take over the surviving component label
            label_reg <= ctl.keep_label;
        end
    end

endmodule

// ===== src/minimum_spanning_tree_kruskal.sv =====
// Kruskal spanning tree top level: edges enter a sorted cell chain, then a scan
// over vertex cells picks tree edges. Loading takes one edge per cycle; each edge
// is sorted on arrival by the chain. After the last edge there is a step of set
// setup, then the scan shifts the chain once per stored edge: an edge in range
// goes through label lookup, then merge, an edge out of range is skipped, and a
// closing step ends the scan; it stops early once the tree is complete.
// Results then leave one at a time through the registered read of the result
// buffer and the output register, each held until the sink takes it. No edge is
// taken while scanning or emitting.
module minimum_spanning_tree_kruskal
(
    input  logic                           clk,
    input  logic                           rst_n,
    mstk_edge_if.sink                      edge_in,
    mstk_tree_if.source                    tree_out,
    input  logic                           vertex_count_we,
    input  logic [mstk_pkg::VC_BITS-1:0]   vertex_count_wdata
);

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_INIT = 7'b0000010,
        S_LOOK = 7'b0000100,
        S_JOIN = 7'b0001000,
        S_RD   = 7'b0010000,
        S_LD   = 7'b0100000,
        S_HOLD = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [mstk_pkg::VC_BITS-1:0]  vc_reg;
    logic [mstk_pkg::VC_BITS-1:0]  nv;
    logic [mstk_pkg::CNT_BITS-1:0] count_reg;
    logic [mstk_pkg::VID_BITS-1:0] chosen_reg;
    logic [mstk_pkg::VID_BITS-1:0] idx_reg;
    logic                          dropped_reg;
    logic                          empty_reg;
    logic [mstk_pkg::VID_BITS-1:0] la_reg, lb_reg;
    mstk_pkg::edge_t               rdata_reg;
    mstk_pkg::edge_t               res_mem [mstk_pkg::MAX_VERTICES];

    mstk_pkg::edge_t   new_edge, head;
    mstk_pkg::edge_t   cell_edge [mstk_pkg::MAX_EDGES];
    logic              cell_gt   [mstk_pkg::MAX_EDGES];
    mstk_pkg::cell_ctl_t cctl;
    mstk_pkg::vtx_ctl_t  vctl;
    logic [mstk_pkg::VID_BITS-1:0] label_w [mstk_pkg::MAX_VERTICES];

    logic accept, in_drop, head_bad, scan_done;

    // Clamp the vertex count to 1..MAX_VERTICES.
    assign nv = (vc_reg == '0) ? mstk_pkg::VC_BITS'(1) :
                (vc_reg > mstk_pkg::VC_BITS'(mstk_pkg::MAX_VERTICES)) ?
                mstk_pkg::VC_BITS'(mstk_pkg::MAX_VERTICES) : vc_reg;

    assign new_edge.src    = edge_in.edge_src;
    assign new_edge.dst    = edge_in.edge_dest;
    assign new_edge.weight = edge_in.edge_weight;

    assign edge_in.ready = (state_reg == S_LOAD);
    assign accept        = edge_in.valid && edge_in.ready;
    assign in_drop = ({1'b0, edge_in.edge_src} >= nv) || ({1'b0, edge_in.edge_dest} >= nv)
                     || (count_reg == mstk_pkg::CNT_BITS'(mstk_pkg::MAX_EDGES));

    assign head      = cell_edge[0];
    assign head_bad  = ({1'b0, head.src} >= nv) || ({1'b0, head.dst} >= nv);
    assign scan_done = (count_reg == '0) || (({1'b0, chosen_reg} + 7'd1) >= nv);

    assign cctl.insert = accept && !in_drop;
    assign cctl.shift  = (state_reg == S_JOIN) || (state_reg == S_LOOK && !scan_done && head_bad);

    assign vctl.init       = (state_reg == S_INIT);
    assign vctl.relabel    = (state_reg == S_JOIN) && (la_reg != lb_reg);
    assign vctl.keep_label = la_reg;
    assign vctl.old_label  = lb_reg;

    for (genvar i = 0; i < mstk_pkg::MAX_EDGES; i++)
    begin : g_cell
        mstk_pkg::edge_t prev_e, next_e;
        logic            prev_g;
        if (i == 0)
        begin : g_first
            assign prev_e = new_edge;
            assign prev_g = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = cell_edge[i-1];
            assign prev_g = cell_gt[i-1];
        end
        if (i == mstk_pkg::MAX_EDGES - 1)
        begin : g_end
            assign next_e = cell_edge[i];
        end
        else
        begin : g_body
            assign next_e = cell_edge[i+1];
        end
        mstk_sort_cell u_cell (
            .clk       (clk),
            .ctl       (cctl),
            .occ       (mstk_pkg::CNT_BITS'(i) < count_reg),
            .new_edge  (new_edge),
            .prev_edge (prev_e),
            .prev_gt   (prev_g),
            .succ_edge (next_e),
            .edge_q    (cell_edge[i]),
            .gt        (cell_gt[i])
        );
    end

    for (genvar v = 0; v < mstk_pkg::MAX_VERTICES; v++)
    begin : g_vtx
        mstk_vertex_cell u_vtx (
            .clk    (clk),
            .rst_n  (rst_n),
            .own_id (mstk_pkg::VID_BITS'(v)),
            .ctl    (vctl),
            .label  (label_w[v])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (accept && edge_in.last_edge) state_next = S_INIT;
            S_INIT: state_next = S_LOOK;
            S_LOOK:
            begin
                if (scan_done)
                    state_next = (chosen_reg == '0) ? S_LD : S_RD;
                else if (!head_bad)
                    state_next = S_JOIN;
            end
            S_JOIN: state_next = S_LOOK;
            S_RD:   state_next = S_LD;
            S_LD:   state_next = S_HOLD;
            S_HOLD:
            begin
                if (tree_out.ready)
                    state_next = tree_out.last_of_tree ? S_LOAD : S_RD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            vc_reg      <= mstk_pkg::VC_BITS'(mstk_pkg::MAX_VERTICES);
            count_reg   <= '0;
            chosen_reg  <= '0;
            idx_reg     <= '0;
            dropped_reg <= 1'b0;
            empty_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (vertex_count_we)
                vc_reg <= vertex_count_wdata;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (in_drop) dropped_reg <= 1'b1;
                        else         count_reg   <= count_reg + 1'b1;
                    end
                end
                S_INIT: chosen_reg <= '0;
                S_LOOK:
                begin
                    if (scan_done)
                    begin
                        count_reg <= '0;
                        idx_reg   <= '0;
                        empty_reg <= (chosen_reg == '0);
                    end
                    else if (head_bad)
                    begin
                        // skip an edge whose endpoint fell out of range
                        dropped_reg <= 1'b1;
                        count_reg   <= count_reg - 1'b1;
                    end
                end
                S_JOIN:
                begin
                    count_reg <= count_reg - 1'b1;
                    if (la_reg != lb_reg)
                        chosen_reg <= chosen_reg + 1'b1;
                end
                S_HOLD:
                begin
                    if (tree_out.ready)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (tree_out.last_of_tree)
                        begin
                            dropped_reg <= 1'b0;
                            chosen_reg  <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK)
        begin
            la_reg <= label_w[head.src];
            lb_reg <= label_w[head.dst];
        end
        if (state_reg == S_JOIN && la_reg != lb_reg)
            res_mem[chosen_reg] <= head;
        rdata_reg <= res_mem[idx_reg];
    end

    // Output register.
    mstk_pkg::edge_t out_reg;
    logic            out_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LD)
        begin
            out_reg      <= empty_reg ? '0 : rdata_reg;
            out_last_reg <= empty_reg || (idx_reg == chosen_reg - 1'b1);
        end
    end

    assign tree_out.valid         = (state_reg == S_HOLD);
    assign tree_out.tree_src      = out_reg.src;
    assign tree_out.tree_dest     = out_reg.dst;
    assign tree_out.tree_weight   = out_reg.weight;
    assign tree_out.last_of_tree  = out_last_reg;
    assign tree_out.empty_tree    = empty_reg;
    assign tree_out.edges_dropped = dropped_reg;

endmodule
